/* src/csr_pkg.sv */
`timescale 1ns / 1ps

package csr_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_ERASE  = 2'd1,
		OP_WEIGHT = 2'd2,
		OP_DEGREE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_INCREMENTED = 3'd1,
		ST_ERASED      = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_FULL        = 3'd4,
		ST_DONE        = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RS_RD,
		S_BOUNDS,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DECIDE,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_ERA_RD,
		S_ERA_WR,
		S_PTR_RD,
		S_PTR_WR,
		S_DEG,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rs_read;
		logic load_bounds;
		logic scan_init;
		logic scan_read;
		logic scan_check;
		logic write_incr;
		logic ins_init;
		logic ins_read;
		logic ins_write;
		logic ins_put;
		logic era_init;
		logic era_read;
		logic era_write;
		logic ptr_init;
		logic ptr_read;
		logic ptr_step;
		logic deg_load;
		logic set_status;
		status_t status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic zero_weight;
		logic out_of_range;
		logic scan_done;
		logic found;
		logic full;
		logic move_done;
		logic ptr_done;
	} sts_t;

endpackage

/* src/csr_adjacency_store.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// input    in         in_valid/in_stall   op, row, column, weight_in
// output   out        out_valid/out_stall status, weight_out, degree, adjacent
//
// One item at a time: a lookup reads the row pointers, loads the bounds, then
// reads and checks the row's entries in turn. An insert shifts entries up and
// an erase shifts them down, one by one, then the later row pointers are
// updated one by one; every memory access is a registered read or one write.
// Reset clears the row pointers at once through valid bits; edge memories
// are not cleared. A stalled result holds; input stalls until it is taken.

module csr_adjacency_store #(
	parameter int VERTICES = 64,
	parameter int EDGE_CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [5:0]         row,
	input  logic [5:0]         column,
	input  logic signed [15:0] weight_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [15:0] weight_out,
	output logic [6:0]         degree,
	output logic               adjacent
);

	csr_pkg::cmd_t cmd;
	csr_pkg::sts_t sts;

	csr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	csr_dpath #(.VERTICES(VERTICES), .EDGE_CAPACITY(EDGE_CAPACITY)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .op(op), .row(row),
		.column(column), .weight_in(weight_in), .status(status),
		.weight_out(weight_out), .degree(degree), .adjacent(adjacent)
	);

endmodule

/* src/csr_ctrl.sv */
`timescale 1ns / 1ps

module csr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  csr_pkg::sts_t sts,
	output csr_pkg::cmd_t cmd
);

	csr_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			csr_pkg::S_IDLE: begin
				if (in_valid) state_d = csr_pkg::S_RS_RD;
			end
			csr_pkg::S_RS_RD: state_d = csr_pkg::S_BOUNDS;
			csr_pkg::S_BOUNDS: state_d = csr_pkg::S_SCAN_RD;
			csr_pkg::S_SCAN_RD: begin
				if (sts.scan_done || sts.found) state_d = csr_pkg::S_DECIDE;
				else state_d = csr_pkg::S_SCAN_CHK;
			end
			csr_pkg::S_SCAN_CHK: state_d = csr_pkg::S_SCAN_RD;
			csr_pkg::S_DECIDE: begin
				state_d = csr_pkg::S_DEG;
				if (sts.op == csr_pkg::OP_ADD && !sts.zero_weight && !sts.out_of_range
						&& !sts.found && !sts.full)
					state_d = csr_pkg::S_INS_RD;
				else if (sts.op == csr_pkg::OP_ERASE && sts.found)
					state_d = csr_pkg::S_ERA_RD;
			end
			csr_pkg::S_INS_RD: begin
				if (sts.move_done) state_d = csr_pkg::S_INS_PUT;
				else state_d = csr_pkg::S_INS_WR;
			end
			csr_pkg::S_INS_WR: state_d = csr_pkg::S_INS_RD;
			csr_pkg::S_INS_PUT: state_d = csr_pkg::S_PTR_RD;
			csr_pkg::S_ERA_RD: begin
				if (sts.move_done) state_d = csr_pkg::S_PTR_RD;
				else state_d = csr_pkg::S_ERA_WR;
			end
			csr_pkg::S_ERA_WR: state_d = csr_pkg::S_ERA_RD;
			csr_pkg::S_PTR_RD: begin
				if (sts.ptr_done) state_d = csr_pkg::S_DEG;
				else state_d = csr_pkg::S_PTR_WR;
			end
			csr_pkg::S_PTR_WR: state_d = csr_pkg::S_PTR_RD;
			csr_pkg::S_DEG: state_d = csr_pkg::S_OUT;
			csr_pkg::S_OUT: begin
				if (!out_stall) state_d = csr_pkg::S_IDLE;
			end
			default: state_d = csr_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		cmd.status = csr_pkg::ST_DONE;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			csr_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			csr_pkg::S_RS_RD: cmd.rs_read = 1'b1;
			csr_pkg::S_BOUNDS: begin
				cmd.load_bounds = 1'b1;
				cmd.scan_init = 1'b1;
			end
			csr_pkg::S_SCAN_RD: begin
				if (!(sts.scan_done || sts.found)) cmd.scan_read = 1'b1;
			end
			csr_pkg::S_SCAN_CHK: cmd.scan_check = 1'b1;
			csr_pkg::S_DECIDE: begin
				cmd.set_status = 1'b1;
				case (sts.op)
					csr_pkg::OP_ADD: begin
						if (sts.zero_weight) cmd.status = csr_pkg::ST_DONE;
						else if (sts.out_of_range) cmd.status = csr_pkg::ST_NOT_FOUND;
						else if (sts.found) begin
							cmd.status = csr_pkg::ST_INCREMENTED;
							cmd.write_incr = 1'b1;
						end else if (sts.full) cmd.status = csr_pkg::ST_FULL;
						else begin
							cmd.status = csr_pkg::ST_INSERTED;
							cmd.ins_init = 1'b1;
						end
					end
					csr_pkg::OP_ERASE: begin
						if (sts.found) begin
							cmd.status = csr_pkg::ST_ERASED;
							cmd.era_init = 1'b1;
						end else cmd.status = csr_pkg::ST_NOT_FOUND;
					end
					default: cmd.status = csr_pkg::ST_DONE;
				endcase
			end
			csr_pkg::S_INS_RD: begin
				if (!sts.move_done) cmd.ins_read = 1'b1;
			end
			csr_pkg::S_INS_WR: cmd.ins_write = 1'b1;
			csr_pkg::S_INS_PUT: begin
				cmd.ins_put = 1'b1;
				cmd.ptr_init = 1'b1;
			end
			csr_pkg::S_ERA_RD: begin
				if (!sts.move_done) cmd.era_read = 1'b1;
				else cmd.ptr_init = 1'b1;
			end
			csr_pkg::S_ERA_WR: cmd.era_write = 1'b1;
			csr_pkg::S_PTR_RD: begin
				if (!sts.ptr_done) cmd.ptr_read = 1'b1;
			end
			csr_pkg::S_PTR_WR: cmd.ptr_step = 1'b1;
			csr_pkg::S_DEG: cmd.deg_load = 1'b1;
			csr_pkg::S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	// An item is taken only from idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == csr_pkg::S_IDLE)
		else $error("input accepted while busy");
	// A result stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
	// Input and output are never both open.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("input open while result pending");

endmodule

/* src/csr_dpath.sv */
`timescale 1ns / 1ps

module csr_dpath #(
	parameter int VERTICES = 64,
	parameter int EDGE_CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csr_pkg::cmd_t      cmd,
	output csr_pkg::sts_t      sts,
	input  logic [1:0]         op,
	input  logic [5:0]         row,
	input  logic [5:0]         column,
	input  logic signed [15:0] weight_in,
	output logic [2:0]         status,
	output logic signed [15:0] weight_out,
	output logic [6:0]         degree,
	output logic               adjacent
);

	localparam int AW = $clog2(EDGE_CAPACITY);
	localparam int PW = $clog2(EDGE_CAPACITY + 1);
	localparam int VW = $clog2(VERTICES + 1);
	localparam logic [PW-1:0] CAP = PW'(EDGE_CAPACITY);

	logic [5:0]  col_mem [EDGE_CAPACITY];
	logic [15:0] wt_mem  [EDGE_CAPACITY];
	logic [PW-1:0] rs_q [VERTICES+1];
	logic [VERTICES:0] rs_valid_q;

	logic [1:0]  op_q;
	logic [5:0]  row_q, col_q;
	logic [15:0] win_q;
	logic        rng_q;
	logic [PW-1:0] lo_q, hi_q, idx_q, total_q, pos_q;
	logic [5:0]  rd_col_q;
	logic [15:0] rd_wt_q;
	logic        found_q;
	logic [AW-1:0] slot_q;
	logic [15:0] fw_q;
	logic [VW-1:0] pi_q;
	logic [2:0]  status_q;
	logic [6:0]  degree_q;
	logic [PW-1:0] rs_lo_q, rs_hi_q, ptr_rd_q, cnt_q;
	logic        rs_lo_ok_q, rs_hi_ok_q, ptr_ok_q;

	logic [PW-1:0] rs_r, rs_r1;
	logic [16:0] incr;
	logic [VW-1:0] row_ext;

	function automatic logic [PW-1:0] bnd(input logic [PW-1:0] v);
		return (v > CAP) ? CAP : v;
	endfunction

	// Registered pointer reads; an unset entry reads as zero.
	assign row_ext = VW'(row_q);
	assign rs_r   = rs_lo_ok_q ? rs_lo_q : '0;
	assign rs_r1  = rs_hi_ok_q ? rs_hi_q : '0;
	assign incr   = 17'(signed'(fw_q)) + 17'sd256;

	// Captured item and scan state.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			row_q <= row;
			col_q <= column;
			win_q <= weight_in;
			rng_q <= (32'(row) >= VERTICES) || (32'(column) >= VERTICES);
		end
		if (cmd.load_bounds) begin
			lo_q    <= bnd(rs_r);
			hi_q    <= bnd(rs_r1);
			idx_q   <= bnd(rs_r);
			total_q <= bnd(cnt_q);
			pos_q   <= bnd(rs_r);
		end
		if (cmd.scan_read) begin
			rd_col_q <= col_mem[idx_q[AW-1:0]];
			rd_wt_q  <= wt_mem[idx_q[AW-1:0]];
		end
		if (cmd.scan_check) begin
			if (rd_col_q == col_q) begin
				slot_q <= idx_q[AW-1:0];
				fw_q   <= rd_wt_q;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.ins_init) idx_q <= total_q;
		if (cmd.era_init) idx_q <= PW'(slot_q);
		if (cmd.ins_read) begin
			rd_col_q <= col_mem[idx_q[AW-1:0] - 1'b1];
			rd_wt_q  <= wt_mem[idx_q[AW-1:0] - 1'b1];
		end
		if (cmd.ins_write) idx_q <= idx_q - 1'b1;
		if (cmd.era_read) begin
			rd_col_q <= col_mem[idx_q[AW-1:0] + 1'b1];
			rd_wt_q  <= wt_mem[idx_q[AW-1:0] + 1'b1];
		end
		if (cmd.era_write) idx_q <= idx_q + 1'b1;
		if (cmd.ptr_init) pi_q <= row_ext + 1'b1;
		if (cmd.ptr_step) pi_q <= pi_q + 1'b1;
		if (cmd.set_status) status_q <= cmd.status;
		// Degree after the operation, from the bounds read before it.
		if (cmd.deg_load) begin
			if (rng_q && 32'(row_q) >= VERTICES) degree_q <= '0;
			else if (hi_q < lo_q) degree_q <= '0;
			else if (status_q == csr_pkg::ST_INSERTED) degree_q <= 7'(hi_q - lo_q + 1'b1);
			else if (status_q == csr_pkg::ST_ERASED) degree_q <= 7'(hi_q - lo_q - 1'b1);
			else degree_q <= 7'(hi_q - lo_q);
		end
	end

	// Found flag is control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_init) begin
			found_q <= 1'b0;
		end else if (cmd.scan_check && rd_col_q == col_q) begin
			found_q <= 1'b1;
		end
	end

	// Number of stored edges.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.ins_put) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.era_init && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Edge memories, one write port.
	always_ff @(posedge clk) begin
		if (cmd.write_incr) begin
			wt_mem[slot_q] <= incr[16:15] == 2'b01 ? 16'h7fff : incr[15:0];
		end else if (cmd.ins_write) begin
			col_mem[idx_q[AW-1:0]] <= rd_col_q;
			wt_mem[idx_q[AW-1:0]]  <= rd_wt_q;
		end else if (cmd.ins_put) begin
			col_mem[pos_q[AW-1:0]] <= col_q;
			wt_mem[pos_q[AW-1:0]]  <= win_q;
		end else if (cmd.era_write) begin
			col_mem[idx_q[AW-1:0]] <= rd_col_q;
			wt_mem[idx_q[AW-1:0]]  <= rd_wt_q;
		end
	end

	// Row pointer valid bits, each set as its pointer is written, one at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_valid_q <= '0;
		end else if (cmd.ptr_step) begin
			rs_valid_q[pi_q] <= 1'b1;
		end
	end

	// Pointer store: registered reads, then a write of the updated pointer.
	always_ff @(posedge clk) begin
		if (cmd.rs_read) begin
			rs_lo_q    <= rs_q[row_ext];
			rs_hi_q    <= rs_q[row_ext + 1'b1];
			rs_lo_ok_q <= rs_valid_q[row_ext];
			rs_hi_ok_q <= rs_valid_q[row_ext + 1'b1];
		end
		if (cmd.ptr_read) begin
			ptr_rd_q <= rs_q[pi_q];
			ptr_ok_q <= rs_valid_q[pi_q];
		end
		if (cmd.ptr_step) begin
			if (status_q == csr_pkg::ST_INSERTED)
				rs_q[pi_q] <= (ptr_ok_q ? ptr_rd_q : '0) + 1'b1;
			else if (ptr_ok_q && ptr_rd_q != '0)
				rs_q[pi_q] <= ptr_rd_q - 1'b1;
			else
				rs_q[pi_q] <= '0;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.op           = csr_pkg::op_t'(op_q);
		sts.zero_weight  = win_q == '0;
		sts.out_of_range = rng_q;
		sts.scan_done    = rng_q || idx_q >= hi_q;
		sts.found        = found_q;
		sts.full         = total_q >= CAP;
		sts.move_done    = (status_q == csr_pkg::ST_INSERTED) ? (idx_q <= pos_q)
			: (idx_q + 1'b1 >= total_q);
		sts.ptr_done     = pi_q > VW'(VERTICES);
	end

	// Result fields.
	assign status     = status_q;
	assign weight_out = (found_q && op_q != csr_pkg::OP_DEGREE) ? fw_q : '0;
	assign adjacent   = found_q && op_q != csr_pkg::OP_DEGREE;
	assign degree     = degree_q;

endmodule
